/* hdl/strmq_pkg.sv */
package strmq_pkg;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 11;
  localparam int LEN_W   = POS_W + 1;
  localparam int LOG_W   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [POS_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;
    logic [POS_W-1:0]        range_low;
    logic [POS_W-1:0]        range_high;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic                    range_error;
  } out_item_t;

  // Position of the highest set bit; zero for a zero input.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (v[i]) begin
        r = LOG_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/strmq_ram.sv */
module strmq_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/strmq_cmp.sv */
module strmq_cmp
  import strmq_pkg::*;
#(
  parameter int IDX_W = 10
) (
  input  logic signed [VAL_W-1:0] val_a,
  input  logic signed [VAL_W-1:0] val_b,
  input  logic [IDX_W-1:0]        idx_a,
  input  logic [IDX_W-1:0]        idx_b,
  output logic signed [VAL_W-1:0] min_val,
  output logic [IDX_W-1:0]        min_idx
);

  logic take_a;

  // On a tie the second block wins.
  assign take_a  = (val_a < val_b);
  assign min_val = take_a ? val_a : val_b;
  assign min_idx = take_a ? idx_a : idx_b;

endmodule

/* hdl/sparse_table_range_minimum_core.sv */
// Range-minimum engine built around a sparse table of minimum positions held in one
// single-port-read table memory, with an element memory of the same kind and one shared
// signed comparator. An element write is taken without leaving the idle state. A query
// passes through two table reads, two element reads and one compare to its result, and
// a refused query goes straight to an error result. A build first fills level 0 and then,
// for each level j >= 1 with 2^j <= n and j < LEVELS, takes one setup step and then fills
// (n - 2^j + 1) entries, each with two table reads and two element reads through the single
// read ports and one compare, and takes one last setup step to finish. The input is stalled
// for the whole of each build and query, and configuration writes are taken only while no item is in progress.
module sparse_table_range_minimum_core
  import strmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int LEVELS       = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W     = $clog2(MAX_ELEMENTS);
  localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int SPAN_W    = CNT_W + 1;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int TAB_AW    = LVL_W + IDX_W;
  localparam int TAB_DEPTH = LEVELS * (2 ** IDX_W);
  localparam int CNT_RST   = (1024 > MAX_ELEMENTS) ? MAX_ELEMENTS : 1024;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FILL = 9'b000000010,
    S_LVL  = 9'b000000100,
    S_TA   = 9'b000001000,
    S_TB   = 9'b000010000,
    S_VA   = 9'b000100000,
    S_VB   = 9'b001000000,
    S_CMP  = 9'b010000000,
    S_ERR  = 9'b100000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    ready_r, ready_nxt;
  logic                    bld_r, bld_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [IDX_W-1:0]        pos_a_r, pos_a_nxt;
  logic [IDX_W-1:0]        pos_b_r, pos_b_nxt;
  logic [SPAN_W-1:0]       span_r, span_nxt;
  logic [IDX_W-1:0]        idx_a_r, idx_a_nxt;
  logic [IDX_W-1:0]        idx_b_r, idx_b_nxt;
  logic signed [VAL_W-1:0] val_a_r, val_a_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic                    cfg_xfer;
  logic                    out_free;
  logic [LEN_W-1:0]        q_len;
  logic [LOG_W-1:0]        q_k;
  logic [LEN_W-1:0]        q_pos_b;
  logic                    q_bad;

  logic                    tab_we;
  logic [TAB_AW-1:0]       tab_waddr;
  logic [IDX_W-1:0]        tab_wdata;
  logic [TAB_AW-1:0]       tab_raddr;
  logic [IDX_W-1:0]        tab_rdata;

  logic                    val_we;
  logic [IDX_W-1:0]        val_waddr;
  logic [IDX_W-1:0]        val_raddr;
  logic [VAL_W-1:0]        val_rdata;

  logic signed [VAL_W-1:0] cmp_val;
  logic [IDX_W-1:0]        cmp_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign q_len   = {1'b0, in_data.range_high} - {1'b0, in_data.range_low} + LEN_W'(1);
  assign q_k     = floor_log2(q_len);
  assign q_pos_b = {1'b0, in_data.range_high} + LEN_W'(1) - (LEN_W'(1) << q_k);
  assign q_bad   = !ready_r || (in_data.range_low > in_data.range_high) ||
                   (32'(in_data.range_high) >= 32'(n_r)) || (32'(q_k) >= LEVELS);

  strmq_ram #(
    .DW    (IDX_W),
    .DEPTH (TAB_DEPTH),
    .AW    (TAB_AW)
  ) u_tab_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_waddr),
    .wr_data (tab_wdata),
    .rd_addr (tab_raddr),
    .rd_data (tab_rdata)
  );

  strmq_ram #(
    .DW    (VAL_W),
    .DEPTH (MAX_ELEMENTS),
    .AW    (IDX_W)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (in_data.element_value),
    .rd_addr (val_raddr),
    .rd_data (val_rdata)
  );

  strmq_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .val_a   (val_a_r),
    .val_b   (val_rdata),
    .idx_a   (idx_a_r),
    .idx_b   (idx_b_r),
    .min_val (cmp_val),
    .min_idx (cmp_idx)
  );

  always_comb begin
    tab_raddr = {lvl_r, pos_b_r};
    if (state_r == S_TA) begin
      tab_raddr = {lvl_r, pos_a_r};
    end
    val_raddr = (state_r == S_VA) ? idx_a_r : idx_b_r;
    val_waddr = IDX_W'(in_data.element_index);
    val_we    = in_xfer && (in_data.kind == KIND_WRITE) &&
                (32'(in_data.element_index) < 32'(MAX_ELEMENTS));
    tab_we    = 1'b0;
    tab_waddr = {LVL_W'(0), pos_a_r};
    tab_wdata = pos_a_r;
    if (state_r == S_CMP && bld_r) begin
      tab_we    = 1'b1;
      tab_waddr = {LVL_W'(lvl_r + LVL_W'(1)), pos_a_r};
      tab_wdata = cmp_idx;
    end else if (state_r == S_FILL) begin
      tab_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    bld_nxt       = bld_r;
    n_nxt         = n_r;
    lvl_nxt       = lvl_r;
    pos_a_nxt     = pos_a_r;
    pos_b_nxt     = pos_b_r;
    span_nxt      = span_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    val_a_nxt     = val_a_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_xfer) begin
      ready_nxt = 1'b0;
      if (cfg_data == '0) begin
        n_nxt = CNT_W'(1);
      end else if (32'(cfg_data) > 32'(MAX_ELEMENTS)) begin
        n_nxt = CNT_W'(MAX_ELEMENTS);
      end else begin
        n_nxt = CNT_W'(cfg_data);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.kind)
            KIND_WRITE: begin
              if (val_we) begin
                ready_nxt = 1'b0;
              end
            end
            KIND_BUILD: begin
              bld_nxt   = 1'b1;
              pos_a_nxt = '0;
              state_nxt = S_FILL;
            end
            KIND_QUERY: begin
              bld_nxt   = 1'b0;
              lvl_nxt   = LVL_W'(q_k);
              pos_a_nxt = IDX_W'(in_data.range_low);
              pos_b_nxt = IDX_W'(q_pos_b);
              state_nxt = q_bad ? S_ERR : S_TA;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        pos_a_nxt = pos_a_r + IDX_W'(1);
        if (32'(pos_a_r) + 1 == 32'(n_r)) begin
          lvl_nxt   = '0;
          span_nxt  = SPAN_W'(2);
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        if ((32'(lvl_r) + 1 < LEVELS) && (32'(span_r) <= 32'(n_r))) begin
          pos_a_nxt = '0;
          pos_b_nxt = IDX_W'(span_r >> 1);
          state_nxt = S_TA;
        end else begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TA: begin
        state_nxt = S_TB;
      end
      S_TB: begin
        idx_a_nxt = tab_rdata;
        state_nxt = S_VA;
      end
      S_VA: begin
        idx_b_nxt = tab_rdata;
        state_nxt = S_VB;
      end
      S_VB: begin
        val_a_nxt = val_rdata;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (bld_r) begin
          pos_a_nxt = pos_a_r + IDX_W'(1);
          pos_b_nxt = pos_b_r + IDX_W'(1);
          if (32'(pos_a_r) + 1 + 32'(span_r) <= 32'(n_r)) begin
            state_nxt = S_TA;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            span_nxt  = span_r << 1;
            state_nxt = S_LVL;
          end
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.min_value   = cmp_val;
          out_data_nxt.range_error = 1'b0;
          state_nxt                = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.min_value   = '0;
          out_data_nxt.range_error = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      bld_r       <= 1'b0;
      n_r         <= CNT_W'(CNT_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      bld_r       <= bld_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    pos_a_r    <= pos_a_nxt;
    pos_b_r    <= pos_b_nxt;
    span_r     <= span_nxt;
    idx_a_r    <= idx_a_nxt;
    idx_b_r    <= idx_b_nxt;
    val_a_r    <= val_a_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hdl/strmq_chk.sv */
module strmq_chk
  import strmq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_data,
  input logic             cfg_ready
);

  // A result that is held back must stay on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A refused query always reports a zero minimum.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> out_data.min_value == '0)
    else $error("error result carries a nonzero minimum");

  // Reset leaves no result on the output.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // An element write keeps the core idle, so the input is open again in the cycle after it.
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_WRITE |=> !in_stall)
    else $error("input stalled after an element write");

  // The configuration port and the input channel are open together.
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !in_stall)
    else $error("configuration port and input channel disagree");

endmodule

bind sparse_table_range_minimum_core strmq_chk u_strmq_chk (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import strmq_pkg::*;

  localparam int NUM_ELEMS      = 1024;
  localparam int NUM_LEVELS     = 11;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 32;
  localparam int PHASE_ITEMS    = 45;
  localparam int WATCHDOG_LIMIT = 200000;

  class rmq_scoreboard;
    logic signed [VAL_W-1:0] element_mem [NUM_ELEMS];
    logic [POS_W-1:0]        pos_table [NUM_LEVELS][NUM_ELEMS];
    bit                      table_valid;
    int unsigned             count;
    out_item_t               pending_minima [$];
    int                      mismatches;

    function new();
      table_valid = 1'b0;
      count       = NUM_ELEMS;
      mismatches  = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      if (v == 0) begin
        count = 1;
      end else if (v > NUM_ELEMS) begin
        count = NUM_ELEMS;
      end else begin
        count = v;
      end
      table_valid = 1'b0;
    endfunction

    function void rebuild_table();
      int unsigned half, a, b;
      for (int i = 0; i < count; i++) pos_table[0][i] = POS_W'(i);
      for (int j = 1; j < NUM_LEVELS && (1 << j) <= count; j++) begin
        half = 1 << (j - 1);
        for (int i = 0; i + (1 << j) <= count; i++) begin
          a = pos_table[j-1][i];
          b = pos_table[j-1][i+half];
          pos_table[j][i] = (element_mem[a] < element_mem[b]) ? POS_W'(a) : POS_W'(b);
        end
      end
      table_valid = 1'b1;
    endfunction

    function out_item_t range_minimum(int unsigned lo, int unsigned hi);
      out_item_t   r;
      int unsigned span, k, a, b;
      r.min_value   = '0;
      r.range_error = 1'b1;
      if (!table_valid || lo > hi || hi >= count) return r;
      span = hi - lo + 1;
      k = 0;
      while ((span >> (k + 1)) != 0) k++;
      if (k >= NUM_LEVELS) return r;
      a = pos_table[k][lo];
      b = pos_table[k][hi + 1 - (1 << k)];
      r.min_value   = (element_mem[a] < element_mem[b]) ? element_mem[a] : element_mem[b];
      r.range_error = 1'b0;
      return r;
    endfunction

    function void note_transfer(in_item_t it);
      case (it.kind)
        KIND_WRITE: begin
          element_mem[it.element_index] = it.element_value;
          table_valid = 1'b0;
        end
        KIND_BUILD: rebuild_table();
        KIND_QUERY: pending_minima.push_back(range_minimum(it.range_low, it.range_high));
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_minima.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: min %0d err %0b", got.min_value, got.range_error);
        end
        return;
      end
      want = pending_minima.pop_front();
      if (got.min_value !== want.min_value || got.range_error !== want.range_error) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected min %0d err %0b, got min %0d err %0b",
                   want.min_value, want.range_error, got.min_value, got.range_error);
        end
      end
    endfunction

    function int backlog();
      return pending_minima.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  rmq_scoreboard rmq_sb = new();
  bit            filled [NUM_ELEMS];
  int            idle_pct;
  int            stall_pct;
  int            items_sent;
  int            builds_left;
  int            quiet_cycles;

  sparse_table_range_minimum_core #(
    .MAX_ELEMENTS(NUM_ELEMS),
    .LEVELS(NUM_LEVELS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) rmq_sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] random_value();
    int near_zero;
    near_zero = $urandom_range(8);
    case ($urandom_range(7))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2, 3: return VAL_W'(near_zero - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rmq_sb.note_transfer(it);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic put_write(input int unsigned idx, input logic signed [VAL_W-1:0] v);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind          = KIND_WRITE;
    it.element_index = POS_W'(idx);
    it.element_value = v;
    filled[idx]      = 1'b1;
    push_item(it);
  endtask

  task automatic put_build();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind = KIND_BUILD;
    push_item(it);
  endtask

  task automatic put_query(input int unsigned lo, input int unsigned hi);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind       = KIND_QUERY;
    it.range_low  = POS_W'(lo);
    it.range_high = POS_W'(hi);
    push_item(it);
  endtask

  task automatic put_spare();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind = KIND_NONE;
    push_item(it);
  endtask

  task automatic put_query_sane(input int unsigned n);
    int unsigned lo, hi, span;
    case ($urandom_range(9))
      0: put_query(0, n - 1);
      1: begin
        span = 1;
        while (span * 2 <= n && $urandom_range(1)) span *= 2;
        lo = $urandom_range(n - span);
        put_query(lo, lo + span - 1);
      end
      2: begin
        hi = $urandom_range(NUM_ELEMS - 2);
        put_query($urandom_range(NUM_ELEMS - 1, hi + 1), hi);
      end
      3: begin
        if (n < NUM_ELEMS) begin
          put_query($urandom_range(NUM_ELEMS - 1), $urandom_range(NUM_ELEMS - 1, n));
        end else begin
          put_query(n - 1, n - 1);
        end
      end
      default: begin
        lo = $urandom_range(n - 1);
        put_query(lo, $urandom_range(n - 1, lo));
      end
    endcase
  endtask

  task automatic load_count(input logic [CFG_W-1:0] v);
    while (rmq_sb.backlog() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rmq_sb.set_count(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Builds only ever see elements that were written, so a build first fills any gaps.
  task automatic random_burst();
    int unsigned n, pick, reps;
    n    = rmq_sb.count;
    pick = $urandom_range(99);
    if (pick < 55) begin
      if (builds_left > 0) begin
        for (int i = 0; i < n; i++) begin
          if (!filled[i]) put_write(i, random_value());
        end
        reps = $urandom_range(3);
        repeat (reps) put_write($urandom_range(n - 1), random_value());
        put_build();
        builds_left--;
      end
      reps = $urandom_range(10, 3);
      repeat (reps) put_query_sane(n);
    end else if (pick < 75 && builds_left > 0) begin
      reps = $urandom_range(4, 1);
      repeat (reps) begin
        if ($urandom_range(3) == 0) begin
          put_write($urandom_range(NUM_ELEMS - 1), random_value());
        end else begin
          put_write($urandom_range(n - 1), random_value());
        end
      end
    end else if (pick < 90) begin
      reps = $urandom_range(6, 1);
      repeat (reps) put_query_sane(n);
    end else begin
      reps = $urandom_range(3, 1);
      repeat (reps) begin
        if ($urandom_range(1)) begin
          put_spare();
        end else begin
          put_query($urandom_range(NUM_ELEMS - 1), $urandom_range(NUM_ELEMS - 1));
        end
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [CFG_W-1:0] cfg);
    int target;
    load_count(cfg);
    idle_pct    = idle;
    stall_pct   = stall;
    builds_left = (rmq_sb.count > 100) ? 3 : 1000;
    target      = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_burst();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    items_sent   = 0;
    builds_left  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    put_query(0, NUM_ELEMS - 1);
    put_spare();
    put_write(NUM_ELEMS - 1, {1'b0, {(VAL_W-1){1'b1}}});
    put_write(0, {1'b1, {(VAL_W-1){1'b0}}});
    load_count(0);
    put_build();
    put_query(0, 0);
    put_query(0, 1);
    put_query(1, 0);
    put_query(NUM_ELEMS - 1, NUM_ELEMS - 1);
    put_write(700, -5);
    put_query(0, 0);

    load_count(5);
    put_write(0, 2);
    put_write(1, 3);
    put_write(2, -1);
    put_write(3, -1);
    put_write(4, 3);
    put_build();
    put_query(0, 4);
    put_query(1, 2);
    put_query(4, 4);
    put_query(2, 3);
    put_query(0, 1);

    load_count({CFG_W{1'b1}});
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (!filled[i]) put_write(i, random_value());
    end
    put_build();
    put_query(0, NUM_ELEMS - 1);
    put_query(NUM_ELEMS - 1, NUM_ELEMS - 1);
    put_query(0, NUM_ELEMS - 2);
    put_query(1, NUM_ELEMS - 1);
    put_query(NUM_ELEMS / 2, NUM_ELEMS - 1);
    repeat (20) put_query_sane(NUM_ELEMS);

    run_phase(0, 0, 37);
    run_phase(87, 0, 16);
    run_phase(0, 87, 3);
    run_phase(36, 36, 64);
    run_phase(0, 0, 2);
    run_phase(87, 0, CFG_W'(NUM_ELEMS));
    run_phase(0, 87, CFG_W'($urandom_range(300, 1)));
    run_phase(36, 36, 128);
    run_phase(0, 0, 1);
    run_phase(36, 36, 9);

    while (rmq_sb.backlog() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (rmq_sb.mismatches == 0 && rmq_sb.backlog() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
